/* hdl/fcs_pkg.sv */
// Shared types and constants for the fault code store.
`default_nettype none

package fcs_pkg;

  localparam int unsigned CODE_W = 24;
  localparam int unsigned STAT_W = 8;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned MAXC_W = 6;
  localparam int unsigned CMD_W  = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = 6'd63;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHK,
    ST_END
  } state_e;

  typedef struct packed {
    logic              accepted;
    logic [CNT_W-1:0]  count;
    logic              entry_valid;
    logic [CODE_W-1:0] code;
    logic [STAT_W-1:0] status;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

/* hdl/fcs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fcs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds data while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/fcs_ctrl.sv */
// Command sequencer: fill count, record append and status-mask scan.
`default_nettype none

module fcs_ctrl #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // command beat
  input  wire logic                        cmd_valid_i,
  output logic                             cmd_ready_o,
  input  wire logic [fcs_pkg::CMD_W-1:0]   cmd_i,
  input  wire logic [fcs_pkg::CODE_W-1:0]  code_i,
  input  wire logic [fcs_pkg::STAT_W-1:0]  status_i,
  input  wire logic [fcs_pkg::STAT_W-1:0]  mask_i,
  input  wire logic [fcs_pkg::MAXC_W-1:0]  max_i,
  // result beat
  output logic                             res_valid_o,
  input  wire logic                        res_ready_i,
  output fcs_pkg::res_t                    res_o
);

  import fcs_pkg::*;

  localparam int unsigned AW  = $clog2(DEPTH > 1 ? DEPTH : 2);
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned CXW = (CW + 1 > MAXC_W + 1) ? CW + 1 : MAXC_W + 1;
  localparam int unsigned RW  = CODE_W + STAT_W;

  state_e state_q, state_d;

  logic [CW-1:0]     fill_q, fill_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     written_q, written_d;
  logic [CW-1:0]     max_q, max_d;
  logic [STAT_W-1:0] mask_q, mask_d;
  res_t              pend_q, pend_d;
  logic              pend_vld_q, pend_vld_d;

  logic          ram_we, ram_re;
  logic [RW-1:0] ram_rdata;
  logic          scan_go;
  logic          match;
  logic          advance;

  logic [CXW-1:0]   fill_x, cnt_x, max_x;
  logic [CNT_W-1:0] fill_sat, cnt_sat;

  fcs_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i ({status_i, code_i}),
    .re_i    (ram_re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Saturate counts and widen the requested maximum for its clamp to the depth
  always_comb begin
    fill_x   = CXW'(fill_q);
    fill_sat = (fill_x > CXW'(CNT_MAX)) ? CNT_MAX : fill_x[CNT_W-1:0];
    cnt_x    = CXW'(written_q) + CXW'(1);
    cnt_sat  = (cnt_x > CXW'(CNT_MAX)) ? CNT_MAX : cnt_x[CNT_W-1:0];
    max_x    = CXW'(max_i);
  end

  assign scan_go = (idx_q < fill_q) && (written_q < max_q);
  assign match   = |(ram_rdata[RW-1:CODE_W] & mask_q);
  assign advance = !match || !pend_vld_q || res_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i == CMD_REPORT) ? ST_SCAN : ST_END;
        end
      end
      ST_SCAN: begin
        state_d = scan_go ? ST_CHK : ST_END;
      end
      ST_CHK: begin
        if (advance) begin
          state_d = ST_SCAN;
        end
      end
      ST_END: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    fill_d      = fill_q;
    idx_d       = idx_q;
    written_d   = written_q;
    max_d       = max_q;
    mask_d      = mask_q;
    pend_d      = pend_q;
    pend_vld_d  = pend_vld_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          pend_d = '0;
          case (cmd_i)
            CMD_ADD: begin
              pend_vld_d = 1'b1;
              if (fill_q < CW'(DEPTH)) begin
                ram_we          = 1'b1;
                fill_d          = fill_q + CW'(1);
                pend_d.accepted = 1'b1;
              end
            end
            CMD_CLEAR: begin
              pend_vld_d   = 1'b1;
              pend_d.count = fill_sat;
              fill_d       = '0;
            end
            CMD_REPORT: begin
              pend_vld_d = 1'b0;
              idx_d      = '0;
              written_d  = '0;
              mask_d     = mask_i;
              max_d      = (max_x > CXW'(DEPTH)) ? CW'(DEPTH) : CW'(max_x);
            end
            default: begin
              pend_vld_d = 1'b0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        ram_re = scan_go;
      end
      ST_CHK: begin
        // Push out the held record once a newer match shows it is not last
        if (match && pend_vld_q) begin
          res_valid_o = 1'b1;
          res_o       = pend_q;
        end
        if (advance) begin
          idx_d = idx_q + CW'(1);
          if (match) begin
            pend_vld_d         = 1'b1;
            pend_d             = '0;
            pend_d.count       = cnt_sat;
            pend_d.entry_valid = 1'b1;
            pend_d.code        = ram_rdata[CODE_W-1:0];
            pend_d.status      = ram_rdata[RW-1:CODE_W];
            written_d          = written_q + CW'(1);
          end
        end
      end
      ST_END: begin
        res_valid_o = 1'b1;
        if (pend_vld_q) begin
          res_o = pend_q;
        end
        res_o.last = 1'b1;
        if (res_ready_i) begin
          pend_vld_d = 1'b0;
        end
      end
      default: begin
        pend_vld_d = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_q     <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  // Scan payload registers
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    written_q <= written_d;
    max_q     <= max_d;
    mask_q    <= mask_d;
    pend_q    <= pend_d;
  end

endmodule

`default_nettype wire

/* hdl/fault_code_store_with_mask_report.sv */
// Add, clear and the unused code: the command beat is taken in ST_IDLE and the result beat
//   is presented from ST_END through the output register; the next command is taken in ST_IDLE.
// Report over n scanned records: each record is a RAM read (ST_SCAN), then a mask compare
//   (ST_CHK), which stalls while a held match cannot be passed on; the last beat is presented
//   from ST_END through the output register; the scan stops at the fill count or once max_count matched.
// Reset clears the fill count and control; record memory is not cleared.
`default_nettype none

module fault_code_store_with_mask_report #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave side
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // fault_code [23:0], fault_status [31:24], match_mask [39:32], max_count [45:40]
  input  wire logic [47:0] s_axis_tdata_i,
  // cmd [1:0]
  input  wire logic [1:0]  s_axis_tuser_i,
  // master side
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // accepted [0], count [6:1], out_code [30:7], out_status [38:31]
  output logic [39:0]      m_axis_tdata_o,
  // entry_valid [0]
  output logic             m_axis_tuser_o,
  output logic             m_axis_tlast_o
);

  import fcs_pkg::*;

  logic res_valid, res_ready;
  res_t res;
  res_t out_q;
  logic out_vld_q;

  fcs_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid_i),
    .cmd_ready_o (s_axis_tready_o),
    .cmd_i       (s_axis_tuser_i),
    .code_i      (s_axis_tdata_i[23:0]),
    .status_i    (s_axis_tdata_i[31:24]),
    .mask_i      (s_axis_tdata_i[39:32]),
    .max_i       (s_axis_tdata_i[45:40]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_vld_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  // Pack the result beat
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_q.status, out_q.code, out_q.count, out_q.accepted};
  assign m_axis_tuser_o  = out_q.entry_valid;
  assign m_axis_tlast_o  = out_q.last;

endmodule

`default_nettype wire
